/* src/fcba_pkg.sv */
// ----------------------------------------------------------------------------
// fcba_pkg
// Shared constants and types of the chain block allocator: table geometry,
// entry codes and the request bundle of the table memory.
// ----------------------------------------------------------------------------
`default_nettype none

package fcba_pkg;

    localparam int TABLE_ENTRIES = 2048;
    localparam int SPAN          = (TABLE_ENTRIES < 2048) ? TABLE_ENTRIES : 2048;
    localparam int ADDR_W        = $clog2(SPAN);
    localparam int BLOCK_W       = 11;
    localparam int ENTRY_W       = 12;
    localparam int REQ_W         = 3;
    localparam int STATUS_W      = 2;

    localparam logic [ENTRY_W-1:0] END_MARK   = {ENTRY_W{1'b1}};
    localparam logic [ENTRY_W-1:0] FREE_ENTRY = '0;
    localparam logic [BLOCK_W-1:0] CFG_RESET  = BLOCK_W'(9);

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 3'd0,
        REQ_NEW    = 3'd1,
        REQ_EXTEND = 3'd2,
        REQ_FREE   = 3'd3,
        REQ_FIND   = 3'd4,
        REQ_SUCC   = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_END   = 2'd2,
        STAT_LIMIT = 2'd3
    } status_t;

    typedef struct packed {
        logic   rd_en;
        addr_t  rd_addr;
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

/* src/fcba_table_ram.sv */
// ----------------------------------------------------------------------------
// fcba_table_ram
// Allocation table memory: one write and one registered read per cycle,
// with a bypass so that a read of the entry written in the same cycle
// returns the new value.
// ----------------------------------------------------------------------------
`default_nettype none

module fcba_table_ram
    import fcba_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t mem_req,
    output entry_t        rd_data
);

    entry_t mem [SPAN];
    entry_t q_reg;
    entry_t byp_data_reg;
    logic   byp_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            q_reg        <= mem[mem_req.rd_addr];
            byp_data_reg <= mem_req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (mem_req.rd_en)
        begin
            byp_reg <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : q_reg;

endmodule

`default_nettype wire

/* src/fat_chain_block_allocator.sv */
// ----------------------------------------------------------------------------
// fat_chain_block_allocator
// Allocation table of block chains: clear, new chain, extend, free chain,
// find last block and successor lookup, run by a small sequencer around
// one table memory.
//
// Channel   Direction  Signals                          Handshake
// request   in         req_type, block                  start && !busy
// result    out        status, block_out                done, one cycle
// config    in         cfg_wr_data                      cfg_wr_en
//
// Every table visit costs one memory read per cycle; the memory port sets
// the rate. New chain and extend scan upward from the configured first block for
// a free entry (extend links the given block to it) and mark it as chain end;
// free chain and find last walk the chain; successor reads one entry; clear frees every entry.
// After reset a clearing pass over all SPAN entries (2048) keeps busy high.
// The result cannot be stalled; the next item may start in the done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_block_allocator
    import fcba_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [REQ_W-1:0]    req_type,
    input  wire logic [BLOCK_W-1:0]  block,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [BLOCK_W-1:0]       block_out,
    input  wire logic                cfg_wr_en,
    input  wire logic [BLOCK_W-1:0]  cfg_wr_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WR_LINK,
        S_WR_MARK,
        S_WALK,
        S_SUCC
    } state_t;

    localparam logic [BLOCK_W:0]  SPAN_CMP  = (BLOCK_W+1)'(SPAN);
    localparam logic [ADDR_W:0]   SPAN_ADDR = (ADDR_W+1)'(SPAN);
    localparam logic [ENTRY_W-1:0] LINK_LIM = ENTRY_W'(SPAN);
    localparam addr_t             LAST_ADDR = ADDR_W'(SPAN - 1);

    state_t               state_reg, state_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    addr_t                cur_reg, cur_next;
    addr_t                blk_reg, blk_next;
    addr_t                cnt_reg, cnt_next;
    logic                 clr_resp_reg, clr_resp_next;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [BLOCK_W-1:0]   bout_reg, bout_next;
    logic [BLOCK_W-1:0]   first_reg;

    mem_req_t             mem_req;
    entry_t               rd_data;

    logic [BLOCK_W-1:0]   scan_start;
    logic                 blk_ok;
    logic [ADDR_W:0]      cur_p1;
    logic                 is_link;

    fcba_table_ram u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    assign scan_start = (first_reg == '0) ? BLOCK_W'(1) : first_reg;
    assign blk_ok     = {1'b0, block} < SPAN_CMP;
    assign cur_p1     = {1'b0, cur_reg} + (ADDR_W+1)'(1);
    assign is_link    = (rd_data != FREE_ENTRY) && (rd_data < LINK_LIM);

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        cur_next      = cur_reg;
        blk_next      = blk_reg;
        cnt_next      = cnt_reg;
        clr_resp_next = clr_resp_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        bout_next     = bout_reg;
        mem_req       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    blk_next = block[ADDR_W-1:0];
                    cur_next = block[ADDR_W-1:0];
                    cnt_next = '0;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        REQ_NEW, REQ_EXTEND:
                        begin
                            if ((req_type == REQ_EXTEND) && !blk_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_END;
                                bout_next   = '0;
                            end
                            else if ({1'b0, scan_start} >= SPAN_CMP)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_FULL;
                                bout_next   = '0;
                            end
                            else
                            begin
                                cur_next        = scan_start[ADDR_W-1:0];
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = scan_start[ADDR_W-1:0];
                                state_next      = S_SCAN;
                            end
                        end
                        REQ_FREE, REQ_FIND, REQ_SUCC:
                        begin
                            if (!blk_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_END;
                                bout_next   = '0;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = block[ADDR_W-1:0];
                                state_next      = (req_type == REQ_SUCC) ? S_SUCC : S_WALK;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_DONE;
                            bout_next   = '0;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_reg;
                mem_req.wr_data = FREE_ENTRY;
                if (cnt_reg == LAST_ADDR)
                begin
                    done_next     = clr_resp_reg;
                    status_next   = STAT_DONE;
                    bout_next     = '0;
                    clr_resp_next = 1'b0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_SCAN:
            begin
                if (rd_data == FREE_ENTRY)
                begin
                    state_next = (req_reg == REQ_EXTEND) ? S_WR_LINK : S_WR_MARK;
                end
                else if (cur_p1 >= SPAN_ADDR)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_FULL;
                    bout_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_next        = cur_p1[ADDR_W-1:0];
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = cur_p1[ADDR_W-1:0];
                end
            end
            S_WR_LINK:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = blk_reg;
                mem_req.wr_data = ENTRY_W'(cur_reg);
                state_next      = S_WR_MARK;
            end
            S_WR_MARK:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_reg;
                mem_req.wr_data = END_MARK;
                done_next       = 1'b1;
                status_next     = STAT_DONE;
                bout_next       = BLOCK_W'(cur_reg);
                state_next      = S_IDLE;
            end
            S_WALK:
            begin
                if (req_reg == REQ_FREE)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = cur_reg;
                    mem_req.wr_data = FREE_ENTRY;
                end
                if (!is_link)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_DONE;
                    bout_next   = (req_reg == REQ_FIND) ? BLOCK_W'(cur_reg) : '0;
                    state_next  = S_IDLE;
                end
                else if (cnt_reg == LAST_ADDR)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_LIMIT;
                    bout_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_next        = rd_data[ADDR_W-1:0];
                    cnt_next        = cnt_reg + ADDR_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_data[ADDR_W-1:0];
                end
            end
            S_SUCC:
            begin
                done_next = 1'b1;
                if (is_link)
                begin
                    status_next = STAT_DONE;
                    bout_next   = BLOCK_W'(rd_data[ADDR_W-1:0]);
                end
                else
                begin
                    status_next = STAT_END;
                    bout_next   = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            clr_resp_reg <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= STAT_DONE;
            bout_reg     <= '0;
            first_reg    <= CFG_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_resp_reg <= clr_resp_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            bout_reg     <= bout_next;
            if (cfg_wr_en)
            begin
                first_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        cur_reg <= cur_next;
        blk_reg <= blk_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign block_out = bout_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result strobe without preceding work");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither worked on nor answered");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_FULL)) |-> (block_out == '0))
        else $error("table full result carries a block");

    a_limit_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_LIMIT)) |-> ((req_reg == REQ_FREE) || (req_reg == REQ_FIND)))
        else $error("walk limit reported for a request without a walk");

endmodule

`default_nettype wire
